// ----- hdl/bibt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bibt_pkg
// Shared types and codes of the binary image boundary tracer.
// ----------------------------------------------------------------------------
package bibt_pkg;

   localparam logic [1:0] FUNC_WRITE  = 2'd0;
   localparam logic [1:0] FUNC_LEFT   = 2'd1;
   localparam logic [1:0] FUNC_RIGHT  = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam logic [1:0] REG_MID_COLUMN     = 2'd0;
   localparam logic [1:0] REG_SCAN_TOP_LIMIT = 2'd1;
   localparam logic [1:0] REG_SCAN_FIRST_ROW = 2'd2;

   localparam logic [6:0] MID_COLUMN_RST     = 7'd64;
   localparam logic [5:0] SCAN_TOP_LIMIT_RST = 6'd4;
   localparam logic [5:0] SCAN_FIRST_ROW_RST = 6'd55;

   localparam int END_MOVES = 3;

   typedef struct packed {
      logic [6:0] mid_column;
      logic [5:0] scan_top_limit;
      logic [5:0] scan_first_row;
   } cfg_type;

endpackage

// ----- hdl/bibt_frame_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bibt_frame_mem
// One-bit frame store, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bibt_frame_mem #(
   parameter int AW = 13
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic          rd_data
);

   logic mem [2**AW];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/bibt_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bibt_core
// Start-row search and boundary walk over the frame store.
// ----------------------------------------------------------------------------
module bibt_core #(
   parameter int FRAME_ROWS = 64,
   parameter int FRAME_COLS = 128,
   parameter int MAX_POINTS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  bibt_pkg::cfg_type  cfg,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic [5:0]         req_pixel_row,
   input  logic [6:0]         req_pixel_col,
   input  logic               req_pixel_white,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [5:0]         rsp_start_row,
   output logic [5:0]         rsp_point_index,
   output logic [7:0]         rsp_point_row,
   output logic [7:0]         rsp_point_col,
   output logic               rsp_last
);

   localparam int RW = $clog2(FRAME_ROWS);
   localparam int CW = $clog2(FRAME_COLS);
   localparam int AW = RW + CW;
   localparam int NW = $clog2(MAX_POINTS + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_TRC  = 2'd2;
   localparam logic [1:0] ST_EVAL = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic              dir_left_ff, dir_left_in;
   logic signed [9:0] x_ff, x_in;
   logic signed [9:0] xd_ff, xd_in;
   logic              rd_v_ff, rd_v_in;
   logic              oob_d_ff, oob_d_in;
   logic [7:0]        hist_ff, hist_in;
   logic [3:0]        seen_ff, seen_in;
   logic              found_v_ff, found_v_in;
   logic [5:0]        found_ff, found_in;
   logic [2:0]        ph_ff, ph_in;
   logic [3:0]        nb_ff, nb_in;
   logic [7:0]        row_ff, row_in;
   logic [7:0]        col_ff, col_in;
   logic [NW-1:0]     n_ff, n_in;
   logic [1:0]        ends_ff, ends_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [5:0]        o_start_ff, o_start_in;
   logic [5:0]        o_index_ff, o_index_in;
   logic [7:0]        o_row_ff, o_row_in;
   logic [7:0]        o_col_ff, o_col_in;
   logic              o_last_ff, o_last_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic              rd_data;
   logic signed [9:0] rd_row, rd_col;
   logic              rd_oob;
   logic              pix;
   logic [7:0]        win;
   logic              kpat, apat;
   logic signed [9:0] lim_s, first_s, j_s;
   logic              c_p, s_p, d_p, u_p;
   logic [7:0]        step;
   logic [1:0]        ends_next;
   logic              out_free;

   bibt_frame_mem #(.AW(AW)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_pixel_white),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign wr_en = req_valid && !req_stall && (req_func == bibt_pkg::FUNC_WRITE)
                  && (int'(req_pixel_row) < FRAME_ROWS)
                  && (int'(req_pixel_col) < FRAME_COLS);
   assign wr_addr = {RW'(req_pixel_row), CW'(req_pixel_col)};

   assign lim_s   = $signed({4'd0, cfg.scan_top_limit});
   assign first_s = $signed({4'd0, cfg.scan_first_row});
   assign step    = dir_left_ff ? 8'hFF : 8'h01;

   always_comb begin
      rd_row = x_ff;
      rd_col = $signed({3'd0, cfg.mid_column});
      if (state_ff == ST_TRC) begin
         rd_row = $signed({2'd0, row_ff});
         rd_col = $signed({2'd0, col_ff});
         if (ph_ff != 3'd0) begin
            rd_col = dir_left_ff ? rd_col - 10'sd1 : rd_col + 10'sd1;
         end
         if (ph_ff == 3'd2) begin
            rd_row = rd_row + 10'sd1;
         end else if (ph_ff == 3'd3) begin
            rd_row = rd_row - 10'sd1;
         end
      end
   end

   assign rd_oob = (rd_row < 10'sd0) || (rd_row >= $signed(10'(FRAME_ROWS)))
                   || (rd_col < 10'sd0) || (rd_col >= $signed(10'(FRAME_COLS)));
   assign rd_addr = {rd_row[RW-1:0], rd_col[CW-1:0]};
   assign rd_en = ((state_ff == ST_SCAN) && (x_ff <= first_s + 10'sd3))
                  || ((state_ff == ST_TRC) && (ph_ff < 3'd4));

   assign pix  = rd_data && !oob_d_ff;
   assign win  = {hist_ff[6:0], pix};
   assign kpat = win[0] && (win[4:1] == 4'd0) && (xd_ff > lim_s);
   assign j_s  = xd_ff - 10'sd3;
   assign apat = (win[3:0] == 4'd0) && (win[6:4] == 3'b111)
                 && (j_s > lim_s) && (j_s <= first_s) && seen_ff[3];

   assign c_p = nb_ff[0];
   assign s_p = nb_ff[1];
   assign d_p = nb_ff[2];
   assign u_p = nb_ff[3];
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      dir_left_in  = dir_left_ff;
      x_in         = x_ff;
      xd_in        = x_ff;
      rd_v_in      = rd_en;
      oob_d_in     = rd_oob;
      hist_in      = hist_ff;
      seen_in      = seen_ff;
      found_v_in   = found_v_ff;
      found_in     = found_ff;
      ph_in        = ph_ff;
      nb_in        = nb_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      n_in         = n_ff;
      ends_in      = ends_ff;
      ends_next    = ends_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      o_start_in   = o_start_ff;
      o_index_in   = o_index_ff;
      o_row_in     = o_row_ff;
      o_col_in     = o_col_ff;
      o_last_in    = o_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_func == bibt_pkg::FUNC_LEFT
                              || req_func == bibt_pkg::FUNC_RIGHT)) begin
               state_in    = ST_SCAN;
               dir_left_in = (req_func == bibt_pkg::FUNC_LEFT);
               x_in        = lim_s - 10'sd3;
               hist_in     = '0;
               seen_in     = '0;
               found_v_in  = 1'b0;
               found_in    = '0;
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               x_in = x_ff + 10'sd1;
            end
            if (rd_v_ff) begin
               hist_in = win;
               seen_in = {seen_ff[2:0], seen_ff[0] | kpat};
               if (apat && !found_v_ff) begin
                  found_v_in = 1'b1;
                  found_in   = j_s[5:0];
               end
            end else if (!rd_en) begin
               state_in = ST_TRC;
               ph_in    = '0;
               row_in   = {2'd0, found_ff};
               col_in   = {1'b0, cfg.mid_column};
               n_in     = '0;
               ends_in  = '0;
            end
         end
         ST_TRC: begin
            if (ph_ff != 3'd0) begin
               nb_in[ph_ff[1:0] - 2'd1] = pix;
            end
            ph_in = ph_ff + 3'd1;
            if (ph_ff == 3'd4) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (out_free) begin
               if (c_p != d_p && c_p != s_p) begin
                  row_in    = row_ff + 8'd1;
                  ends_next = ends_ff + 2'd1;
               end else if (c_p != s_p && c_p == d_p) begin
                  row_in = row_ff + 8'd1;
                  col_in = col_ff + step;
               end else if (c_p == s_p && c_p == d_p && c_p != u_p) begin
                  col_in = col_ff + step;
               end else if (c_p == s_p && c_p == d_p && c_p == u_p) begin
                  row_in    = row_ff - 8'd1;
                  col_in    = col_ff + step;
                  ends_next = ends_ff + 2'd1;
               end
               ends_in      = ends_next;
               rsp_valid_in = 1'b1;
               o_start_in   = found_ff;
               o_index_in   = n_ff[5:0];
               o_row_in     = row_in;
               o_col_in     = col_in;
               o_last_in    = (n_ff == NW'(MAX_POINTS - 1))
                              || (int'(ends_next) >= bibt_pkg::END_MOVES);
               n_in         = n_ff + 1'b1;
               ph_in        = '0;
               state_in     = o_last_in ? ST_IDLE : ST_TRC;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         n_ff         <= '0;
         ends_ff      <= '0;
         ph_ff        <= '0;
         found_v_ff   <= 1'b0;
         seen_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rd_v_ff      <= rd_v_in;
         rsp_valid_ff <= rsp_valid_in;
         n_ff         <= n_in;
         ends_ff      <= ends_in;
         ph_ff        <= ph_in;
         found_v_ff   <= found_v_in;
         seen_ff      <= seen_in;
      end
      dir_left_ff <= dir_left_in;
      x_ff        <= x_in;
      xd_ff       <= xd_in;
      oob_d_ff    <= oob_d_in;
      hist_ff     <= hist_in;
      found_ff    <= found_in;
      nb_ff       <= nb_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      o_start_ff  <= o_start_in;
      o_index_ff  <= o_index_in;
      o_row_ff    <= o_row_in;
      o_col_ff    <= o_col_in;
      o_last_ff   <= o_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_start_row   = o_start_ff;
   assign rsp_point_index = o_index_ff;
   assign rsp_point_row   = o_row_ff;
   assign rsp_point_col   = o_col_ff;
   assign rsp_last        = o_last_ff;

   a_n_bound: assert property (@(posedge clock) disable iff (reset)
      int'(n_ff) <= MAX_POINTS)
      else $error("point count past limit");

   a_ends_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVAL |-> int'(ends_ff) < bibt_pkg::END_MOVES)
      else $error("walk continued after final end move");

   a_load_eval: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EVAL)
      else $error("result loaded outside evaluation");

   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !wr_en)
      else $error("frame write during trace");

endmodule

// ----- hdl/binary_image_boundary_tracer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_image_boundary_tracer_top
// Frame store loader and eight-neighbour boundary tracer with register port.
// ----------------------------------------------------------------------------
//  channel  ports                         role
//  req      req_valid/req_stall + fields  pixel write or trace command in
//  rsp      rsp_valid/rsp_stall + fields  one traced point out
//  csr      psel/penable/pwrite/...       mid_column, scan_top_limit,
//                                         scan_first_row
//
//  Pixel writes stream back to back while the tracer is idle.
//  A trace runs the start search, one frame read per row, then for each
//  point four reads (the point and three neighbours) through the single
//  memory read port plus evaluation.
//  Synchronous reset clears control; the frame store is not cleared.
//  A stalled point holds the walk until it is taken.
// ----------------------------------------------------------------------------
module binary_image_boundary_tracer_top #(
   parameter int FRAME_ROWS = 64,
   parameter int FRAME_COLS = 128,
   parameter int MAX_POINTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [5:0]  req_pixel_row,
   input  logic [6:0]  req_pixel_col,
   input  logic        req_pixel_white,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_start_row,
   output logic [5:0]  rsp_point_index,
   output logic [7:0]  rsp_point_row,
   output logic [7:0]  rsp_point_col,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   bibt_pkg::cfg_type cfg_ff, cfg_in;
   logic              csr_wr;
   logic [1:0]        csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr  = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr && csr_paddr[1:0] == 2'd0) begin
         case (csr_idx)
            bibt_pkg::REG_MID_COLUMN:     cfg_in.mid_column     = csr_pwdata[6:0];
            bibt_pkg::REG_SCAN_TOP_LIMIT: cfg_in.scan_top_limit = csr_pwdata[5:0];
            bibt_pkg::REG_SCAN_FIRST_ROW: cfg_in.scan_first_row = csr_pwdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         bibt_pkg::REG_MID_COLUMN:     csr_prdata = {25'd0, cfg_ff.mid_column};
         bibt_pkg::REG_SCAN_TOP_LIMIT: csr_prdata = {26'd0, cfg_ff.scan_top_limit};
         bibt_pkg::REG_SCAN_FIRST_ROW: csr_prdata = {26'd0, cfg_ff.scan_first_row};
         default:                      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mid_column     <= bibt_pkg::MID_COLUMN_RST;
         cfg_ff.scan_top_limit <= bibt_pkg::SCAN_TOP_LIMIT_RST;
         cfg_ff.scan_first_row <= bibt_pkg::SCAN_FIRST_ROW_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bibt_core #(
      .FRAME_ROWS (FRAME_ROWS),
      .FRAME_COLS (FRAME_COLS),
      .MAX_POINTS (MAX_POINTS)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_pixel_row   (req_pixel_row),
      .req_pixel_col   (req_pixel_col),
      .req_pixel_white (req_pixel_white),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_start_row   (rsp_start_row),
      .rsp_point_index (rsp_point_index),
      .rsp_point_row   (rsp_point_row),
      .rsp_point_col   (rsp_point_col),
      .rsp_last        (rsp_last)
   );

endmodule
